FILE: rtl/fwhs_pkg.sv
// ----------------------------------------------------------------------------
// fwhs_pkg
// Shared types and codes for the circular FIFO with in-place heap sort.
// ----------------------------------------------------------------------------
package fwhs_pkg;

  // Data word and default store depth
  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 64;

  // Request codes
  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_SORT = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Sort sequencer status toward the FIFO control
  typedef struct packed {
    logic busy;
    logic done;
  } sort_status_t;

endpackage

FILE: rtl/fwhs_mem.sv
// ----------------------------------------------------------------------------
// fwhs_mem
// Word store: one write port, two read ports, registered read data that
// holds its value while the port's read enable is low.
// ----------------------------------------------------------------------------
module fwhs_mem #(
  parameter int DEPTH = fwhs_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               wen,
  input  logic [IDX_W-1:0]                   waddr,
  input  logic signed [fwhs_pkg::WORD_W-1:0] wdata,
  input  logic                               ren_a,
  input  logic [IDX_W-1:0]                   raddr_a,
  output logic signed [fwhs_pkg::WORD_W-1:0] rdata_a,
  input  logic                               ren_b,
  input  logic [IDX_W-1:0]                   raddr_b,
  output logic signed [fwhs_pkg::WORD_W-1:0] rdata_b
);

  logic signed [fwhs_pkg::WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports
  always_ff @(posedge clk) begin
    if (ren_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (ren_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/fwhs_sort.sv
// ----------------------------------------------------------------------------
// fwhs_sort
// Heap sort sequencer. Works in place on the store through a logical-to-
// physical map (head + index, wrapped). Builds a max-heap, then swaps the
// root to the end and sifts down. Sift-down holds the moving word in a
// register, reads both children together, then compares and writes.
// ----------------------------------------------------------------------------
module fwhs_sort #(
  parameter int DEPTH = fwhs_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [IDX_W-1:0]                   head,
  input  logic [CNT_W-1:0]                   count,
  output fwhs_pkg::sort_status_t             stat,
  output logic                               ren_a,
  output logic [IDX_W-1:0]                   raddr_a,
  input  logic signed [fwhs_pkg::WORD_W-1:0] rdata_a,
  output logic                               ren_b,
  output logic [IDX_W-1:0]                   raddr_b,
  input  logic signed [fwhs_pkg::WORD_W-1:0] rdata_b,
  output logic                               wen,
  output logic [IDX_W-1:0]                   waddr,
  output logic signed [fwhs_pkg::WORD_W-1:0] wdata
);

  localparam int CH_W = IDX_W + 2;
  localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_BLD_RD   = 3'd1;
  localparam logic [2:0] S_BLD_V    = 3'd2;
  localparam logic [2:0] S_SIFT_RD  = 3'd3;
  localparam logic [2:0] S_SIFT_CMP = 3'd4;
  localparam logic [2:0] S_EX_RD    = 3'd5;
  localparam logic [2:0] S_EX_WR    = 3'd6;

  localparam logic PH_BUILD   = 1'b0;
  localparam logic PH_EXTRACT = 1'b1;

  logic [2:0]                         state, state_next;
  logic                               phase, phase_next;
  logic [IDX_W-1:0]                   k, k_next;
  logic [IDX_W-1:0]                   e, e_next;
  logic [IDX_W-1:0]                   root, root_next;
  logic [CNT_W-1:0]                   size, size_next;
  logic signed [fwhs_pkg::WORD_W-1:0] v, v_next;
  logic                               right_ok, right_ok_next;

  logic [CH_W-1:0]                    lc, rc, size_x, big;
  logic                               has_l, has_r;
  logic signed [fwhs_pkg::WORD_W-1:0] bv;
  logic                               sift_done, done;

  // Logical index to physical slot
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                            input logic [IDX_W-1:0] j);
    logic [IDX_W:0] sum;
    sum = {1'b0, hd} + {1'b0, j};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  // Children of the current root and the larger one
  always_comb begin
    lc     = (CH_W'(root) << 1) + CH_W'(1);
    rc     = (CH_W'(root) << 1) + CH_W'(2);
    size_x = CH_W'(size);
    has_l  = lc < size_x;
    has_r  = rc < size_x;
    if (right_ok && (rdata_b > rdata_a)) begin
      big = rc;
      bv  = rdata_b;
    end else begin
      big = lc;
      bv  = rdata_a;
    end
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    k_next        = k;
    e_next        = e;
    root_next     = root;
    size_next     = size;
    v_next        = v;
    right_ok_next = right_ok;
    ren_a         = 1'b0;
    ren_b         = 1'b0;
    raddr_a       = head;
    raddr_b       = head;
    wen           = 1'b0;
    waddr         = phys(head, root);
    wdata         = v;
    sift_done     = 1'b0;
    done          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          phase_next = PH_BUILD;
          k_next     = IDX_W'((count >> 1) - CNT_W'(1));
          state_next = S_BLD_RD;
        end
      end
      S_BLD_RD: begin
        ren_a      = 1'b1;
        raddr_a    = phys(head, k);
        root_next  = k;
        size_next  = count;
        state_next = S_BLD_V;
      end
      S_BLD_V: begin
        v_next     = rdata_a;
        state_next = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        // a leaf takes the moving word at once
        if (has_l) begin
          ren_a         = 1'b1;
          raddr_a       = phys(head, lc[IDX_W-1:0]);
          ren_b         = has_r;
          raddr_b       = phys(head, rc[IDX_W-1:0]);
          right_ok_next = has_r;
          state_next    = S_SIFT_CMP;
        end else begin
          wen       = 1'b1;
          sift_done = 1'b1;
        end
      end
      S_SIFT_CMP: begin
        wen = 1'b1;
        if (bv > v) begin
          wdata      = bv;
          root_next  = big[IDX_W-1:0];
          state_next = S_SIFT_RD;
        end else begin
          sift_done = 1'b1;
        end
      end
      S_EX_RD: begin
        ren_a      = 1'b1;
        raddr_a    = head;
        ren_b      = 1'b1;
        raddr_b    = phys(head, e);
        state_next = S_EX_WR;
      end
      S_EX_WR: begin
        // old root goes to the end, the end word sifts down from the root
        wen        = 1'b1;
        waddr      = phys(head, e);
        wdata      = rdata_a;
        v_next     = rdata_b;
        root_next  = '0;
        size_next  = CNT_W'(e);
        state_next = S_SIFT_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Next root, next extraction or finish once a sift ends
    if (sift_done) begin
      if (phase == PH_BUILD) begin
        if (k == '0) begin
          phase_next = PH_EXTRACT;
          e_next     = IDX_W'(count - CNT_W'(1));
          state_next = S_EX_RD;
        end else begin
          k_next     = k - IDX_W'(1);
          state_next = S_BLD_RD;
        end
      end else begin
        if (e == IDX_W'(1)) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end else begin
          e_next     = e - IDX_W'(1);
          state_next = S_EX_RD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    phase    <= phase_next;
    k        <= k_next;
    e        <= e_next;
    root     <= root_next;
    size     <= size_next;
    v        <= v_next;
    right_ok <= right_ok_next;
  end

  assign stat.busy = (state != S_IDLE);
  assign stat.done = done;

endmodule

FILE: rtl/fifo_with_inplace_heap_sort_top.sv
// ----------------------------------------------------------------------------
// fifo_with_inplace_heap_sort_top
// Circular FIFO of signed words with an in-place ascending heap sort.
//
//   channel | signals                       | direction
//   --------+-------------------------------+----------
//   in      | in_valid, in_stall, req_type, | request
//           | push_value                    |
//   out     | out_valid, out_stall, status, | result
//           | pop_value, occupancy          |
//
// Enqueue and dequeue requests may follow back to back while the input is not
// stalled; the dequeue word comes from the store's registered read port. A
// sort of n > 1 words holds the input stalled while it sifts each root (n/2
// of them) and runs each extraction (n-1 of them), its pace set by the
// store's two read ports and one write port. Each result sits in an
// output register; the input stalls only while it waits or a sort runs.
// Reset empties the FIFO; store contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_inplace_heap_sort_top #(
  parameter int DEPTH = fwhs_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         req_type,
  input  logic signed [fwhs_pkg::WORD_W-1:0] push_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic signed [fwhs_pkg::WORD_W-1:0] pop_value,
  output logic [CNT_W-1:0]                   occupancy
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;

  logic             p_valid, p_valid_next;
  logic [1:0]       p_status, p_status_next;
  logic             p_pop, p_pop_next;
  logic [CNT_W-1:0] p_occ, p_occ_next;

  logic             accept, sort_start;
  logic [IDX_W-1:0] tail_inc, head_inc;

  fwhs_pkg::sort_status_t             sort_stat;
  logic                               s_ren_a, s_ren_b, s_wen;
  logic [IDX_W-1:0]                   s_raddr_a, s_raddr_b, s_waddr;
  logic signed [fwhs_pkg::WORD_W-1:0] s_wdata;

  logic                               f_ren, f_wen;
  logic                               m_ren_a, m_ren_b, m_wen;
  logic [IDX_W-1:0]                   m_raddr_a, m_raddr_b, m_waddr;
  logic signed [fwhs_pkg::WORD_W-1:0] m_wdata, rdata_a, rdata_b;

  assign in_stall = sort_stat.busy || (p_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + IDX_W'(1);
  assign head_inc = (head == LAST_IDX) ? '0 : head + IDX_W'(1);

  // Request decode and pointer update
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    f_ren         = 1'b0;
    f_wen         = 1'b0;
    sort_start    = 1'b0;
    p_status_next = fwhs_pkg::ST_OK;
    p_pop_next    = 1'b0;
    if (accept) begin
      unique case (req_type)
        fwhs_pkg::REQ_ENQ: begin
          if (count == FULL_CNT) begin
            p_status_next = fwhs_pkg::ST_FULL;
          end else begin
            f_wen      = 1'b1;
            tail_next  = tail_inc;
            count_next = count + CNT_W'(1);
          end
        end
        fwhs_pkg::REQ_DEQ: begin
          if (count == '0) begin
            p_status_next = fwhs_pkg::ST_EMPTY;
          end else begin
            f_ren      = 1'b1;
            p_pop_next = 1'b1;
            head_next  = head_inc;
            count_next = count - CNT_W'(1);
          end
        end
        fwhs_pkg::REQ_SORT: begin
          sort_start = (count > CNT_W'(1));
        end
        default: begin
        end
      endcase
    end
    p_occ_next = count_next;

    // Result register: loaded per transaction or at sort completion
    if (accept && !sort_start) begin
      p_valid_next = 1'b1;
    end else if (sort_stat.done) begin
      p_valid_next = 1'b1;
    end else if (p_valid && !out_stall) begin
      p_valid_next = 1'b0;
    end else begin
      p_valid_next = p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= LAST_IDX;
      count   <= '0;
      p_valid <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      p_valid <= p_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((accept && !sort_start) || sort_stat.done) begin
      p_status <= p_status_next;
      p_pop    <= p_pop_next;
      p_occ    <= p_occ_next;
    end
  end

  assign out_valid = p_valid;
  assign status    = p_status;
  assign pop_value = p_pop ? rdata_a : '0;
  assign occupancy = p_occ;

  // Store port sharing: sorter owns the store while busy
  always_comb begin
    if (sort_stat.busy) begin
      m_ren_a   = s_ren_a;
      m_raddr_a = s_raddr_a;
      m_wen     = s_wen;
      m_waddr   = s_waddr;
      m_wdata   = s_wdata;
    end else begin
      m_ren_a   = f_ren;
      m_raddr_a = head;
      m_wen     = f_wen;
      m_waddr   = tail_inc;
      m_wdata   = push_value;
    end
  end
  assign m_ren_b   = s_ren_b;
  assign m_raddr_b = s_raddr_b;

  fwhs_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wen     (m_wen),
    .waddr   (m_waddr),
    .wdata   (m_wdata),
    .ren_a   (m_ren_a),
    .raddr_a (m_raddr_a),
    .rdata_a (rdata_a),
    .ren_b   (m_ren_b),
    .raddr_b (m_raddr_b),
    .rdata_b (rdata_b)
  );

  fwhs_sort #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_sort (
    .clk     (clk),
    .rst     (rst),
    .start   (sort_start),
    .head    (head),
    .count   (count),
    .stat    (sort_stat),
    .ren_a   (s_ren_a),
    .raddr_a (s_raddr_a),
    .rdata_a (rdata_a),
    .ren_b   (s_ren_b),
    .raddr_b (s_raddr_b),
    .rdata_b (rdata_b),
    .wen     (s_wen),
    .waddr   (s_waddr),
    .wdata   (s_wdata)
  );

endmodule
